### sv/kfifo_pkg.sv
// shared types and constants of the keyed removal fifo
// used by the interfaces, the controller, the datapath and the top level
package kfifo_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned PidBits = 16;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned StatW   = 2;

  typedef logic [PidBits-1:0] pid_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    srch;
    logic    hit;
    logic    shift;
    logic    dec;
    logic    set_status;
    status_e status;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
    logic shift_last;
  } dp_status_t;

endpackage

### sv/kfifo_if.sv
// request and response channels of the keyed removal fifo
// depends on kfifo_pkg for the field widths
interface kfifo_req_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  kfifo_pkg::pid_t      pid;

  modport source (output valid, output operation, output pid, input ready);
  modport sink   (input valid, input operation, input pid, output ready);
endinterface

interface kfifo_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [kfifo_pkg::StatW-1:0] status;
  kfifo_pkg::pid_t            removed_pid;
  logic                       head_valid;
  kfifo_pkg::pid_t            head_pid;
  logic [4:0]                 count;

  modport source (output valid, output status, output removed_pid, output head_valid,
                  output head_pid, output count, input ready);
  modport sink   (input valid, input status, input removed_pid, input head_valid,
                  input head_pid, input count, output ready);
endinterface

### sv/kfifo_dp.sv
// datapath of the keyed removal fifo: entry memory, count, head copy,
// search and shift pointers and the response register; depends on kfifo_pkg
module kfifo_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kfifo_pkg::cmd_t         cmd_i,
  output kfifo_pkg::dp_status_t   st_o,
  input  logic                    operation_i,
  input  kfifo_pkg::pid_t         pid_i,
  output kfifo_pkg::status_e      status_o,
  output kfifo_pkg::pid_t         removed_pid_o,
  output logic                    head_valid_o,
  output kfifo_pkg::pid_t         head_pid_o,
  output logic [4:0]              count_o
);
  import kfifo_pkg::*;

  pid_t    mem [Depth];
  pid_t    rdata_q;
  cnt_t    cnt_q;
  logic    rv_q;
  idx_t    idx_q;
  idx_t    cidx_q;
  idx_t    wa_q;
  pid_t    head_q;
  pid_t    removed_q;
  op_e     op_q;
  pid_t    key_q;
  status_e status_q;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[cnt_q[IdxW-1:0]] <= key_q;
    end else if (cmd_i.shift && rv_q) begin
      mem[wa_q] <= rdata_q;
    end
    if (cmd_i.srch || cmd_i.shift) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        cnt_q <= cnt_q + cnt_t'(1);
      end else if (cmd_i.dec) begin
        cnt_q <= cnt_q - cnt_t'(1);
      end
      if (cmd_i.load || cmd_i.hit) begin
        rv_q <= 1'b0;
      end else if (cmd_i.srch || cmd_i.shift) begin
        rv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(operation_i);
      key_q     <= pid_i;
      idx_q     <= '0;
      removed_q <= '0;
    end
    if (cmd_i.srch) begin
      idx_q  <= idx_q + idx_t'(1);
      cidx_q <= idx_q;
    end
    if (cmd_i.hit) begin
      // shift reads one past the hit and writes at the hit
      idx_q     <= cidx_q + idx_t'(1);
      wa_q      <= cidx_q;
      removed_q <= rdata_q;
    end
    if (cmd_i.shift) begin
      idx_q <= idx_q + idx_t'(1);
      if (rv_q) begin
        wa_q <= wa_q + idx_t'(1);
        if (wa_q == '0) begin
          head_q <= rdata_q;
        end
      end
    end
    if (cmd_i.append && (cnt_q == '0)) begin
      head_q <= key_q;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.finish) begin
      status_o      <= status_q;
      removed_pid_o <= removed_q;
      head_valid_o  <= (cnt_q != '0);
      head_pid_o    <= (cnt_q != '0) ? head_q : '0;
      count_o       <= 5'(cnt_q);
    end
  end

  assign st_o.is_remove  = (op_q == OP_REMOVE);
  assign st_o.full       = (cnt_q == cnt_t'(Depth));
  assign st_o.empty      = (cnt_q == '0);
  assign st_o.hit        = rv_q && (rdata_q == key_q);
  assign st_o.scan_last  = rv_q && ((cnt_t'(cidx_q) + cnt_t'(1)) == cnt_q);
  assign st_o.shift_last = rv_q && ((cnt_t'(wa_q) + cnt_t'(2)) == cnt_q);

endmodule

### sv/kfifo_ctrl.sv
// controller of the keyed removal fifo: sequences append, search and shift
// and owns both handshakes; depends on kfifo_pkg
module kfifo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  kfifo_pkg::dp_status_t st_i,
  output kfifo_pkg::cmd_t       cmd_o
);
  import kfifo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SRCH  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status = ST_OK;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.set_status = 1'b1;
        if (!st_i.is_remove) begin
          if (st_i.full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.append = 1'b1;
          end
          state_d = S_DONE;
        end else if (st_i.empty) begin
          cmd_o.status = ST_EMPTY;
          state_d      = S_DONE;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        // one entry read per cycle, compared in the cycle after it is read
        priority if (st_i.hit) begin
          cmd_o.hit = 1'b1;
          if (st_i.scan_last) begin
            cmd_o.dec = 1'b1;
            state_d   = S_DONE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (st_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.srch = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (st_i.shift_last) begin
          cmd_o.dec = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/keyed_removal_fifo.sv
// Ordered queue of up to 16 process identifiers with append at the tail and
// removal of the first entry that matches a key, the gap being closed so the
// other entries keep their order. Each request gives one response with status,
// removed identifier, head and count. A remove searches from the head, and a
// match that is not the last entry is followed by a shift of the later entries.
// The entries sit in a memory with one read and one write port, so the search
// and the shift each move one entry per cycle. One request is worked on at a
// time. The next request can be accepted as soon as the response turns valid,
// even while that response still waits to be taken. Reset clears the count
// and the handshakes. The entry memory is not cleared, as only entries below
// the count are ever used, so no clearing pass is needed.
module keyed_removal_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfifo_req_if.sink   req,
  kfifo_rsp_if.source rsp
);
  import kfifo_pkg::*;

  cmd_t       cmd;
  dp_status_t st;
  status_e    status;

  kfifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  kfifo_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .operation_i   (req.operation),
    .pid_i         (req.pid),
    .status_o      (status),
    .removed_pid_o (rsp.removed_pid),
    .head_valid_o  (rsp.head_valid),
    .head_pid_o    (rsp.head_pid),
    .count_o       (rsp.count)
  );

  assign rsp.status = status;

endmodule

### test/tb_top.sv
// self-checking bench for keyed_removal_fifo: directed table, then random append and remove
// requests checked against a local queue predictor
// depends on kfifo_pkg and the kfifo_req_if / kfifo_rsp_if interfaces
`timescale 1ns / 100ps

module tb_top;
  import kfifo_pkg::*;

  typedef struct packed {
    status_e    status;
    pid_t       removed;
    logic       head_valid;
    pid_t       head;
    logic [4:0] count;
  } queue_outcome_t;

  typedef struct {
    op_e            op;
    pid_t           pid;
    int             reps;
    bit             typed;
    queue_outcome_t outcome;
  } stim_row_t;

  localparam int RandomRequests = 900;
  localparam int DrainCycles    = 40;

  logic clk;
  logic rst_n;

  kfifo_req_if req_bus ();
  kfifo_rsp_if rsp_bus ();

  keyed_removal_fifo dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_bus),
    .rsp   (rsp_bus)
  );

  // predictor state: head at index 0
  pid_t model_pids [Depth];
  int   model_count;

  queue_outcome_t pending_outcomes [$];
  int             error_count;
  int             send_idle_pct;
  int             rsp_stall_pct;
  int             rsp_hold_cycles;

  // typed outcomes only where they are obvious; the rest come from the predictor
  stim_row_t directed_rows [17] = '{
    '{OP_REMOVE, 16'h0000, 1, 1'b1, '{ST_EMPTY,     16'h0000, 1'b0, 16'h0000, 5'd0}},
    '{OP_APPEND, 16'hFFFF, 1, 1'b1, '{ST_OK,        16'h0000, 1'b1, 16'hFFFF, 5'd1}},
    '{OP_APPEND, 16'h0000, 1, 1'b1, '{ST_OK,        16'h0000, 1'b1, 16'hFFFF, 5'd2}},
    '{OP_REMOVE, 16'h1234, 1, 1'b1, '{ST_NOT_FOUND, 16'h0000, 1'b1, 16'hFFFF, 5'd2}},
    '{OP_REMOVE, 16'hFFFF, 1, 1'b1, '{ST_OK,        16'hFFFF, 1'b1, 16'h0000, 5'd1}},
    '{OP_REMOVE, 16'h0000, 1, 1'b1, '{ST_OK,        16'h0000, 1'b0, 16'h0000, 5'd0}},
    '{OP_APPEND, 16'hA5A5, 1, 1'b0, '0},
    '{OP_APPEND, 16'h5A5A, 1, 1'b0, '0},
    '{OP_APPEND, 16'hA5A5, 1, 1'b0, '0},
    '{OP_APPEND, 16'h8000, 13, 1'b0, '0},
    '{OP_APPEND, 16'h7777, 1, 1'b1, '{ST_FULL,      16'h0000, 1'b1, 16'hA5A5, 5'd16}},
    '{OP_REMOVE, 16'hA5A5, 1, 1'b0, '0},
    '{OP_REMOVE, 16'h800C, 1, 1'b0, '0},
    '{OP_REMOVE, 16'h8006, 1, 1'b0, '0},
    '{OP_REMOVE, 16'h5A5A, 1, 1'b0, '0},
    '{OP_REMOVE, 16'hA5A5, 1, 1'b0, '0},
    '{OP_REMOVE, 16'hFFFF, 1, 1'b0, '0}
  };

  function automatic queue_outcome_t predict_queue_step(op_e op, pid_t pid);
    queue_outcome_t res;
    int hit_at;
    res = '0;
    res.status = ST_OK;
    hit_at = -1;
    if (op == OP_APPEND) begin
      if (model_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        model_pids[model_count] = pid;
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      for (int k = 0; k < model_count; k++) begin
        if (hit_at < 0 && model_pids[k] == pid) hit_at = k;
      end
      if (hit_at < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.removed = model_pids[hit_at];
        for (int k = hit_at; k + 1 < model_count; k++) model_pids[k] = model_pids[k+1];
        model_count--;
      end
    end
    res.head_valid = (model_count != 0);
    res.head       = (model_count != 0) ? model_pids[0] : '0;
    res.count      = model_count[4:0];
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(op_e op, pid_t pid, bit typed, queue_outcome_t typed_outcome);
    queue_outcome_t predicted;
    req_bus.valid     = 1'b1;
    req_bus.operation = op;
    req_bus.pid       = pid;
    do @(posedge clk); while (!req_bus.ready);
    predicted = predict_queue_step(op, pid);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    req_bus.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: mismatch on %s: expected %h actual %h", $time, field, exp_val, act_val);
      error_count++;
    end
  endtask

  task automatic compare_outcome();
    queue_outcome_t exp_out;
    if (pending_outcomes.size() == 0) begin
      $display("%0t: unexpected response: expected none actual status %h count %0d",
               $time, rsp_bus.status, rsp_bus.count);
      error_count++;
    end else begin
      exp_out = pending_outcomes.pop_front();
      report_field("status", exp_out.status, rsp_bus.status);
      report_field("removed_pid", exp_out.removed, rsp_bus.removed_pid);
      report_field("head_valid", exp_out.head_valid, rsp_bus.head_valid);
      report_field("head_pid", exp_out.head, rsp_bus.head_pid);
      report_field("count", exp_out.count, rsp_bus.count);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // response side: random stall, plus a long hold-off on demand
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_bus.ready = 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) compare_outcome();
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    op_e  op;
    pid_t pid;
    int   append_pct;
    req_bus.valid     = 1'b0;
    req_bus.operation = OP_APPEND;
    req_bus.pid       = '0;
    error_count       = 0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    rsp_hold_cycles   = 0;
    model_count       = 0;
    foreach (model_pids[k]) model_pids[k] = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++) begin
        send_request(directed_rows[r].op, directed_rows[r].pid + pid_t'(n),
                     directed_rows[r].typed, directed_rows[r].outcome);
      end
    end
    wait_drained();

    for (int i = 0; i < RandomRequests; i++) begin
      unique case ((i / 60) % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
        default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
      endcase
      // alternate filling and draining so both full and empty get hit
      append_pct = ((i / 50) % 2 != 0) ? 75 : 35;
      // response side stops while requests keep coming, so the input backs up
      if (i == 300) rsp_hold_cycles = 250;
      if (i == 600) wait_drained();

      op = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_REMOVE;
      if (op == OP_REMOVE && model_count > 0 && $urandom_range(99) < 75) begin
        pid = model_pids[$urandom_range(model_count - 1)];
      end else if ($urandom_range(99) < 40) begin
        // small pool of keys gives duplicates in the queue
        pid = 16'hC000 | pid_t'($urandom_range(7));
      end else begin
        pid = pid_t'($urandom);
      end
      send_request(op, pid, 1'b0, '0);
      sender_gap();
    end

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
